/* rtl/core/bdq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Types and constants shared by the bounded deque with search.
// ----------------------------------------------------------------------------
package bdq_pkg;

  // Default sizes of the store
  localparam int unsigned DefaultDepth      = 16;
  localparam int unsigned DefaultValueWidth = 32;

  // Fixed widths of the port fields
  localparam int unsigned ValueInW   = 32;
  localparam int unsigned CountOutW  = 5;
  localparam int unsigned FuncW      = 3;
  localparam int unsigned StatusW    = 2;

  typedef enum logic [FuncW-1:0] {
    OP_ADD_BACK  = 3'd0,
    OP_ADD_FRONT = 3'd1,
    OP_REMOVE    = 3'd2,
    OP_CONTAINS  = 3'd3,
    OP_CLEAR     = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_RDWAIT = 4'b0100,
    S_RESP   = 4'b1000
  } state_e;

endpackage

/* rtl/core/bounded_deque_with_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Ring-buffer deque with add at either end, remove at the front, clear and a
// sequential contains search over the stored entries.
// ----------------------------------------------------------------------------
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------
//   in      | input     | in_valid_i / in_stall_o | func_i, value_i
//   out     | output    | out_valid_o/ out_stall_i| removed_value_o, found_o,
//           |           |                         | status_o, entry_count_o,
//           |           |                         | is_empty_o
//
// One item at a time: add, clear and unused codes go from accept straight to
// the result, remove passes through a read wait first, and contains walks the
// entries, since the single memory read port fetches one stored entry per
// cycle for the compare. The input stalls from accept until the result is taken.
// Reset clears the count and the front slot; entry contents are left as is.
// A stalled result holds on the output until out_stall_i drops.
// ----------------------------------------------------------------------------
module bounded_deque_with_search
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH       = DefaultDepth,
  parameter int unsigned VALUE_WIDTH = DefaultValueWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [FuncW-1:0]     func_i,
  input  logic [ValueInW-1:0]  value_i,

  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ValueInW-1:0]  removed_value_o,
  output logic                 found_o,
  output logic [StatusW-1:0]   status_o,
  output logic [CountOutW-1:0] entry_count_o,
  output logic                 is_empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned VW = VALUE_WIDTH;

  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt  = CW'(DEPTH);
  localparam logic [CW:0]   DepthW   = (CW + 1)'(DEPTH);

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   front_q, front_d;
  logic [AW-1:0]   scan_q, scan_d;
  logic [CW-1:0]   k_q, k_d;
  logic [VW-1:0]   key_q, key_d;
  logic [VW-1:0]   removed_q, removed_d;
  logic            found_q, found_d;
  status_e         status_q, status_d;

  logic [VW-1:0]   mem_q [DEPTH];
  logic [VW-1:0]   rd_data_q;
  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr, wr_addr;

  logic [VW-1:0]   in_val;
  logic [CW:0]     back_sum;
  logic [AW-1:0]   back_slot, front_dec, front_inc, scan_inc;
  logic            is_full, is_empty;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    return (s == LastSlot) ? '0 : s + AW'(1);
  endfunction

  // Take the value in its low VALUE_WIDTH bits, or zero-extend it when wider
  if (VW <= ValueInW) begin : g_in_trunc
    assign in_val = value_i[VW-1:0];
  end else begin : g_in_ext
    assign in_val = {{(VW - ValueInW){1'b0}}, value_i};
  end

  assign is_full   = (count_q == FullCnt);
  assign is_empty  = (count_q == '0);

  // Slot behind the last entry: front + count, wrapped once
  assign back_sum  = (CW + 1)'(front_q) + (CW + 1)'(count_q);
  assign back_slot = (back_sum >= DepthW) ? AW'(back_sum - DepthW) : AW'(back_sum);
  assign front_dec = (front_q == '0) ? LastSlot : front_q - AW'(1);
  assign front_inc = slot_inc(front_q);
  assign scan_inc  = slot_inc(scan_q);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    front_d   = front_q;
    scan_d    = scan_q;
    k_d       = k_q;
    key_d     = key_q;
    removed_d = removed_q;
    found_d   = found_q;
    status_d  = status_q;
    wr_en     = 1'b0;
    wr_addr   = back_slot;
    rd_en     = 1'b0;
    rd_addr   = front_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          removed_d = '0;
          found_d   = 1'b0;
          status_d  = ST_OK;
          state_d   = S_RESP;
          unique case (func_i)
            OP_ADD_BACK: begin
              if (is_full) begin
                status_d = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = back_slot;
                count_d = count_q + CW'(1);
              end
            end
            OP_ADD_FRONT: begin
              if (is_full) begin
                status_d = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = front_dec;
                front_d = front_dec;
                count_d = count_q + CW'(1);
              end
            end
            OP_REMOVE: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                front_d = front_inc;
                count_d = count_q - CW'(1);
                state_d = S_RDWAIT;
              end
            end
            OP_CONTAINS: begin
              if (!is_empty) begin
                // fetch the front entry, then walk toward the back
                rd_en   = 1'b1;
                scan_d  = front_inc;
                k_d     = CW'(1);
                key_d   = in_val;
                state_d = S_SEARCH;
              end
            end
            OP_CLEAR: begin
              count_d = '0;
              front_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_SEARCH: begin
        if (rd_data_q == key_q) begin
          found_d = 1'b1;
          state_d = S_RESP;
        end else if (k_q == count_q) begin
          state_d = S_RESP;
        end else begin
          rd_en   = 1'b1;
          rd_addr = scan_q;
          scan_d  = scan_inc;
          k_d     = k_q + CW'(1);
        end
      end
      S_RDWAIT: begin
        removed_d = rd_data_q;
        state_d   = S_RESP;
      end
      S_RESP: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      front_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      front_q <= front_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q    <= scan_d;
    k_q       <= k_d;
    key_q     <= key_d;
    removed_q <= removed_d;
    found_q   <= found_d;
    status_q  <= status_d;
  end

  // Entry store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= in_val;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_RESP);
  assign found_o     = found_q;
  assign status_o    = status_q;
  assign is_empty_o  = is_empty;

  if (VW >= ValueInW) begin : g_out_trunc
    assign removed_value_o = removed_q[ValueInW-1:0];
  end else begin : g_out_ext
    assign removed_value_o = {{(ValueInW - VW){1'b0}}, removed_q};
  end

  if (CW >= CountOutW) begin : g_cnt_trunc
    assign entry_count_o = count_q[CountOutW-1:0];
  end else begin : g_cnt_ext
    assign entry_count_o = {{(CountOutW - CW){1'b0}}, count_q};
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bounded_deque_with_search. A directed sequence
// covers empty and full stores, both add ends, searches, clear and the unused
// codes. A long random run follows with fill and drain phases. A deque
// tracker predicts every result and checks the results field by field, while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import bdq_pkg::*;

  typedef struct {
    logic [ValueInW-1:0]  removed;
    logic                 found;
    status_e              status;
    logic [CountOutW-1:0] count;
    logic                 empty;
  } reply_t;

  // Shadow copy of the store; predicts one reply for each accepted item.
  class deque_tracker;
    logic [ValueInW-1:0] slots [DefaultDepth];
    int unsigned front;
    int unsigned count;
    reply_t      replies [$];
    int          errors;

    function new();
      front  = 0;
      count  = 0;
      errors = 0;
    endfunction

    function int unsigned slot_at(int unsigned offset);
      return (front + offset) % DefaultDepth;
    endfunction

    function int pending();
      return replies.size();
    endfunction

    function void note_op(logic [FuncW-1:0] func, logic [ValueInW-1:0] value);
      reply_t r;
      r.removed = '0;
      r.found   = 1'b0;
      r.status  = ST_OK;
      case (func)
        OP_ADD_BACK: begin
          if (count >= DefaultDepth) begin
            r.status = ST_FULL;
          end else begin
            slots[slot_at(count)] = value;
            count++;
          end
        end
        OP_ADD_FRONT: begin
          if (count >= DefaultDepth) begin
            r.status = ST_FULL;
          end else begin
            front = slot_at(DefaultDepth - 1);
            slots[front] = value;
            count++;
          end
        end
        OP_REMOVE: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.removed = slots[front];
            front = slot_at(1);
            count--;
          end
        end
        OP_CONTAINS: begin
          for (int unsigned k = 0; k < count; k++) begin
            if (slots[slot_at(k)] == value) r.found = 1'b1;
          end
        end
        OP_CLEAR: begin
          count = 0;
          front = 0;
        end
        default: ;
      endcase
      r.count = count[CountOutW-1:0];
      r.empty = (count == 0);
      replies.push_back(r);
    endfunction

    function void check_reply(logic [ValueInW-1:0] removed, logic found,
                              logic [StatusW-1:0] status,
                              logic [CountOutW-1:0] entry_count, logic empty);
      reply_t r;
      if (replies.size() == 0) begin
        $error("result arrived with no item outstanding");
        errors++;
        return;
      end
      r = replies.pop_front();
      if (removed !== r.removed) begin
        $error("removed_value: expected %h, got %h", r.removed, removed);
        errors++;
      end
      if (found !== r.found) begin
        $error("found: expected %0d, got %0d", r.found, found);
        errors++;
      end
      if (status !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, status);
        errors++;
      end
      if (entry_count !== r.count) begin
        $error("entry_count: expected %0d, got %0d", r.count, entry_count);
        errors++;
      end
      if (empty !== r.empty) begin
        $error("is_empty: expected %0d, got %0d", r.empty, empty);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [FuncW-1:0]     func_i = '0;
  logic [ValueInW-1:0]  value_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [ValueInW-1:0]  removed_value_o;
  logic                 found_o;
  logic [StatusW-1:0]   status_o;
  logic [CountOutW-1:0] entry_count_o;
  logic                 is_empty_o;

  deque_tracker        tracker = new();
  logic [ValueInW-1:0] recent_values [$];
  int unsigned         burst_left = 0;
  bit                  hold_request = 1'b0;
  int unsigned         hold_left = 0;
  int unsigned         stall_mode = 0;
  int unsigned         mode_left = 0;
  int unsigned         cycle_count = 0;

  bounded_deque_with_search dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .removed_value_o (removed_value_o),
    .found_o         (found_o),
    .status_o        (status_o),
    .entry_count_o   (entry_count_o),
    .is_empty_o      (is_empty_o)
  );

  always #4 clk_i = ~clk_i;

  // Result side: check taken results, then pick the stall for the next cycle.
  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_reply(removed_value_o, found_o, status_o, entry_count_o, is_empty_o);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 300;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(5, 60);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= cycle_count[1];
      endcase
    end
  end

  // Idle the input now and then: bursts of random length, random gaps.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic send_item(input logic [FuncW-1:0] func, input logic [ValueInW-1:0] value);
    in_valid_i <= 1'b1;
    func_i     <= func;
    value_i    <= value;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_op(func, value);
    if (func == OP_ADD_BACK || func == OP_ADD_FRONT) begin
      recent_values.push_back(value);
      if (recent_values.size() > DefaultDepth) void'(recent_values.pop_front());
    end
    pace_sender();
  endtask

  // Hold the input until every outstanding result has been taken.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ValueInW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 15);
    if (r < 50) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [ValueInW-1:0] pick_search_value();
    if (recent_values.size() != 0 && $urandom_range(0, 1) == 0) begin
      return recent_values[$urandom_range(0, recent_values.size() - 1)];
    end
    return pick_value();
  endfunction

  initial begin
    int unsigned r;
    int unsigned add_share;
    logic [FuncW-1:0] func;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty store, both add ends, searches, unused codes.
    send_item(OP_REMOVE, 32'hDEAD_BEEF);
    send_item(OP_CONTAINS, 32'h0000_0000);
    send_item(OP_ADD_BACK, 32'h0000_0000);
    send_item(OP_ADD_FRONT, 32'hFFFF_FFFF);
    send_item(OP_CONTAINS, 32'h0000_0000);
    send_item(OP_CONTAINS, 32'hFFFF_FFFF);
    send_item(OP_CONTAINS, 32'h0000_0005);
    for (int i = 5; i < 8; i++) send_item(FuncW'(i), 32'h5555_AAAA);
    // Fill to capacity from both ends, then try to add past it.
    for (int i = 0; i < DefaultDepth - 2; i++) begin
      send_item((i % 2) ? OP_ADD_FRONT : OP_ADD_BACK, {16'hA5A5, 16'(i)});
    end
    send_item(OP_ADD_BACK, 32'h1234_5678);
    send_item(OP_ADD_FRONT, 32'h8765_4321);
    send_item(OP_CONTAINS, {16'hA5A5, 16'(DefaultDepth - 3)});
    send_item(OP_REMOVE, 32'h0);
    send_item(OP_CLEAR, 32'hFFFF_FFFF);
    send_item(OP_REMOVE, 32'h0);
    drain_results();

    // Hold the result side off while items keep coming.
    hold_request = 1'b1;
    add_share = 35;
    for (int n = 0; n < 1600; n++) begin
      if (n % 60 == 0) add_share = 25 + 10 * $urandom_range(0, 2);
      if (n == 800) drain_results();
      r = $urandom_range(0, 99);
      if (r < 1) begin
        send_item(OP_CLEAR, $urandom);
      end else if (r < 3) begin
        func = FuncW'($urandom_range(5, 7));
        send_item(func, $urandom);
      end else if (r < 30) begin
        send_item(OP_CONTAINS, pick_search_value());
      end else if (r < 30 + add_share) begin
        send_item($urandom_range(0, 1) ? OP_ADD_FRONT : OP_ADD_BACK, pick_value());
      end else begin
        send_item(OP_REMOVE, $urandom);
      end
    end

    drain_results();
    repeat (40) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("bounded_deque_with_search test passed");
    end else begin
      $display("bounded_deque_with_search test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("bounded_deque_with_search test failed");
    $finish;
  end

endmodule
